// ----- hw/rtl/sbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_pkg: shared types and codes for the segment/box clip test
// Request and response payloads, outcome codes and side codes.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int CoordBits = 16;
   localparam int FracBits  = 16;

   typedef enum logic [1:0] {
      OUT_MISS   = 2'd0,
      OUT_INSIDE = 2'd1,
      OUT_ENTER  = 2'd2,
      OUT_RSVD   = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      SIDE_LEFT   = 2'd0,
      SIDE_RIGHT  = 2'd1,
      SIDE_TOP    = 2'd2,
      SIDE_BOTTOM = 2'd3
   } side_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] seg_start_x;
      logic signed [CoordBits-1:0] seg_start_y;
      logic signed [CoordBits-1:0] seg_end_x;
      logic signed [CoordBits-1:0] seg_end_y;
      logic signed [CoordBits-1:0] box_left;
      logic signed [CoordBits-1:0] box_top;
      logic        [CoordBits-2:0] box_width;
      logic        [CoordBits-2:0] box_height;
   } req_type;

   typedef struct packed {
      outcome_type         outcome;
      side_type            entry_side;
      logic [FracBits:0]   entry_time;
   } rsp_type;

endpackage

// ----- hw/rtl/sbc_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_div_step: one registered stage of the restoring fraction divider
// Produces STEP_BITS quotient bits of num/den per stage, carrying the rest.
// ----------------------------------------------------------------------------
module sbc_div_step #(
   parameter int W         = 18,
   parameter int QW        = 16,
   parameter int STEP_BITS = 4
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [W-1:0]  rem_in,
   input  logic [W-1:0]  den_in,
   input  logic [QW-1:0] quo_in,
   output logic [W-1:0]  rem_out,
   output logic [W-1:0]  den_out,
   output logic [QW-1:0] quo_out
);
   logic [W-1:0]  rem_ff, den_ff;
   logic [QW-1:0] quo_ff;
   logic [W-1:0]  rem_in_v;
   logic [QW-1:0] quo_in_v;

   // iterate shift-compare-subtract; remainder stays below den
   always_comb begin
      logic [W:0] r;
      rem_in_v = rem_in;
      quo_in_v = quo_in;
      for (int i = 0; i < STEP_BITS; i++) begin
         r = {rem_in_v, 1'b0};
         quo_in_v = {quo_in_v[QW-2:0], 1'b0};
         if (r >= {1'b0, den_in}) begin
            r = r - {1'b0, den_in};
            quo_in_v[0] = 1'b1;
         end
         rem_in_v = r[W-1:0];
      end
   end

   // hold when stalled
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in_v;
         den_ff <= den_in;
         quo_ff <= quo_in_v;
      end
   end

   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;
endmodule

// ----- hw/rtl/segment_box_clip_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_clip_test: segment versus axis-aligned box test
// Early rejects, Liang-Barsky entry/exit selection by cross-multiplication,
// and a pipelined restoring divider for the entry fraction.
// ----------------------------------------------------------------------------
//   channel | direction | payload  | handshake
//   req     | in        | req_type | req_valid / req_stall
//   rsp     | out       | rsp_type | rsp_valid / rsp_stall
//
// One request enters per clock while req_stall is low. Stages in order:
// deltas, compare products, selection, then divider stages of four quotient
// bits each. Reset clears all stage valid bits. The pipeline advances as one;
// rsp_stall freezes every stage only while the last stage holds a result, and
// req_stall is high only while the last stage holds a result that rsp refuses.
module segment_box_clip_test (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sbc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sbc_pkg::rsp_type rsp_data
);
   import sbc_pkg::*;

   localparam int CB   = CoordBits;
   localparam int DW   = CB + 2;           // deltas and q terms
   localparam int PW   = 2 * DW;           // products
   localparam int STEP = 4;
   localparam int NDIV = FracBits / STEP;
   localparam int NST  = 3 + NDIV;

   logic adv;
   logic [NST-1:0] vld_ff;
   assign adv       = !(vld_ff[NST-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NST-1];

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // stage 1: deltas, box edges, early exits
   logic signed [DW-1:0] p_in [4], q_in [4];
   logic signed [DW-1:0] p_ff [4], q_ff [4];
   logic early_in, early_ff;
   outcome_type eoc_in, eoc_ff;

   always_comb begin
      logic signed [DW-1:0] x0, y0, x1, y1, bx0, by0, bx1, by1, dx, dy;
      logic signed [DW-1:0] mnx, mxx, mny, mxy;
      x0  = DW'(req_data.seg_start_x);
      y0  = DW'(req_data.seg_start_y);
      x1  = DW'(req_data.seg_end_x);
      y1  = DW'(req_data.seg_end_y);
      bx0 = DW'(req_data.box_left);
      by0 = DW'(req_data.box_top);
      bx1 = bx0 + $signed({3'b0, req_data.box_width}) - DW'(1);
      by1 = by0 + $signed({3'b0, req_data.box_height}) - DW'(1);
      dx  = x1 - x0;
      dy  = y1 - y0;
      mnx = (x0 < x1) ? x0 : x1;
      mxx = (x0 < x1) ? x1 : x0;
      mny = (y0 < y1) ? y0 : y1;
      mxy = (y0 < y1) ? y1 : y0;
      p_in[0] = -dx; p_in[1] = dx; p_in[2] = -dy; p_in[3] = dy;
      q_in[0] = x0 - bx0; q_in[1] = bx1 - x0;
      q_in[2] = y0 - by0; q_in[3] = by1 - y0;
      early_in = 1'b1;
      eoc_in   = OUT_MISS;
      if (req_data.box_width == '0 || req_data.box_height == '0) begin
         eoc_in = OUT_MISS;
      end else if (dx == '0 && dy == '0) begin
         eoc_in = (x0 < bx0 || y0 < by0 || x0 > bx1 || y0 > by1) ? OUT_MISS : OUT_INSIDE;
      end else if (mxx < bx0 || mnx > bx1 || mxy < by0 || mny > by1) begin
         eoc_in = OUT_MISS;
      end else if (mnx >= bx0 && mny >= by0 && mxx <= bx1 && mxy <= by1) begin
         eoc_in = OUT_INSIDE;
      end else begin
         early_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= p_in; q_ff <= q_in;
         early_ff <= early_in; eoc_ff <= eoc_in;
      end
   end

   // stage 2: per-axis candidate cross products
   // entry candidates n/d with n=-q, d=-p on sides with p<0; x side 0 or 1,
   // y side 2 or 3; same for exits. Parallel axes never reject here.
   logic signed [DW-1:0] en_x, ed_x, en_y, ed_y, xn_x, xd_x, xn_y, xd_y;
   logic hx, hy;
   logic [1:0] sx, sy;
   always_comb begin
      hx = p_ff[0] != '0;
      hy = p_ff[2] != '0;
      // motion toward +x enters on the left and leaves on the right
      if (p_ff[0] < 0) begin
         sx = SIDE_LEFT;  en_x = -q_ff[0]; ed_x = p_ff[1]; xn_x = q_ff[1];
      end else begin
         sx = SIDE_RIGHT; en_x = -q_ff[1]; ed_x = p_ff[0]; xn_x = q_ff[0];
      end
      // motion toward +y enters on the top and leaves on the bottom
      if (p_ff[2] < 0) begin
         sy = SIDE_TOP;    en_y = -q_ff[2]; ed_y = p_ff[3]; xn_y = q_ff[3];
      end else begin
         sy = SIDE_BOTTOM; en_y = -q_ff[3]; ed_y = p_ff[2]; xn_y = q_ff[2];
      end
      xd_x = ed_x;
      xd_y = ed_y;
   end

   logic signed [PW-1:0] m_enx_ff, m_eny_ff, m_xnx_ff, m_xny_ff;
   logic signed [PW-1:0] m_xx_en_ff, m_xy_en_ff, m_xy_enx_ff, m_xx_eny_ff;
   logic signed [DW-1:0] enx_ff, edx_ff, eny_ff, edy_ff;
   logic hx_ff, hy_ff, early2_ff;
   logic [1:0] sx_ff, sy_ff;
   outcome_type eoc2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         m_enx_ff    <= PW'(en_x) * PW'(ed_y);   // en_x*ed_y vs en_y*ed_x
         m_eny_ff    <= PW'(en_y) * PW'(ed_x);
         m_xnx_ff    <= PW'(xn_x) * PW'(xd_y);   // exit compare
         m_xny_ff    <= PW'(xn_y) * PW'(xd_x);
         m_xx_en_ff  <= PW'(xn_x) * PW'(ed_x);   // exit_x vs entry_x
         m_xy_en_ff  <= PW'(xn_y) * PW'(ed_y);
         m_xy_enx_ff <= PW'(xn_y) * PW'(ed_x);   // exit_y vs entry_x
         m_xx_eny_ff <= PW'(xn_x) * PW'(ed_y);   // exit_x vs entry_y
         enx_ff <= en_x; edx_ff <= ed_x; eny_ff <= en_y; edy_ff <= ed_y;
         hx_ff <= hx; hy_ff <= hy; sx_ff <= sx; sy_ff <= sy;
         early2_ff <= early_ff; eoc2_ff <= eoc_ff;
      end
   end

   // stage 3: pick entry (earlier side wins ties) and exit, final checks
   // products carry the matching denominators (xd_x pairs with ed_x etc.)
   logic signed [PW-1:0] m_en_xd_x, m_en_xd_y;
   logic signed [DW-1:0] en_s, ed_s;
   logic [1:0] side_s;
   logic pick_y, exit_y, miss_s;
   logic signed [PW-1:0] lhs, rhs;
   always_comb begin
      // entry: y wins when x is parallel or en_y/ed_y > en_x/ed_x strictly
      pick_y = !hx_ff || (hy_ff && (m_eny_ff > m_enx_ff));
      // exit: y wins when x is parallel or xn_y/xd_y < xn_x/xd_x strictly
      exit_y = !hx_ff || (hy_ff && (m_xny_ff < m_xnx_ff));
      en_s   = pick_y ? eny_ff : enx_ff;
      ed_s   = pick_y ? edy_ff : edx_ff;
      side_s = pick_y ? sy_ff : sx_ff;
      // exit < entry: xn*ed < en*xd; xd equals ed on the same axis
      m_en_xd_x = pick_y ? m_xx_eny_ff : m_xx_en_ff; // xn_x * ed_s
      m_en_xd_y = pick_y ? m_xy_en_ff : m_xy_enx_ff; // xn_y * ed_s
      lhs = exit_y ? m_en_xd_y : m_en_xd_x;
      rhs = PW'(en_s) * PW'(exit_y ? edy_ff : edx_ff);
      miss_s = (lhs < rhs) || (en_s > ed_s) || (en_s < 0);
   end

   logic [DW-1:0] rem_s_ff, den_s_ff;
   logic [FracBits-1:0] quo0;
   logic full_ff;
   logic [1:0] side_ff;
   outcome_type oc_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_s_ff <= en_s;
         den_s_ff <= ed_s;
         full_ff  <= en_s == ed_s;
         side_ff  <= side_s;
         oc_ff    <= early2_ff ? eoc2_ff : (miss_s ? OUT_MISS : OUT_ENTER);
      end
   end
   assign quo0 = '0;

   // divider stages
   logic [DW-1:0]       rem_c [NDIV+1];
   logic [DW-1:0]       den_c [NDIV+1];
   logic [FracBits-1:0] quo_c [NDIV+1];
   logic [1:0]          side_c [NDIV+1];
   logic                full_c [NDIV+1];
   outcome_type         oc_c [NDIV+1];
   assign rem_c[0] = rem_s_ff; assign den_c[0] = den_s_ff; assign quo_c[0] = quo0;
   assign side_c[0] = side_ff; assign full_c[0] = full_ff; assign oc_c[0] = oc_ff;

   for (genvar g = 0; g < NDIV; g++) begin : g_div
      logic [1:0] sd_ff;
      logic fl_ff;
      outcome_type o_ff;
      sbc_div_step #(.W(DW), .QW(FracBits), .STEP_BITS(STEP)) u_step (
         .clock   (clock),
         .enable  (adv),
         .rem_in  (rem_c[g]),
         .den_in  (den_c[g]),
         .quo_in  (quo_c[g]),
         .rem_out (rem_c[g+1]),
         .den_out (den_c[g+1]),
         .quo_out (quo_c[g+1])
      );
      always_ff @(posedge clock) begin
         if (adv) begin
            sd_ff <= side_c[g]; fl_ff <= full_c[g]; o_ff <= oc_c[g];
         end
      end
      assign side_c[g+1] = sd_ff;
      assign full_c[g+1] = fl_ff;
      assign oc_c[g+1]   = o_ff;
   end

   // drive response; unused fields zero
   always_comb begin
      rsp_data.outcome    = oc_c[NDIV];
      rsp_data.entry_side = SIDE_LEFT;
      rsp_data.entry_time = '0;
      if (oc_c[NDIV] == OUT_ENTER) begin
         rsp_data.entry_side = side_type'(side_c[NDIV]);
         rsp_data.entry_time = full_c[NDIV] ? {1'b1, {FracBits{1'b0}}}
                                            : {1'b0, quo_c[NDIV]};
      end
   end
endmodule

// ----- tb/segment_box_clip_test_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_clip_test_tb: self-checking bench for the segment/box clip test
// Directed corner cases, then random segments and boxes under several
// idle/stall mixes; every response is checked against a local clip predictor.
// ----------------------------------------------------------------------------
module segment_box_clip_test_tb;
   import sbc_pkg::*;

   localparam int  RandItems  = 1500;
   localparam longint CycleLimit = 400000;
   localparam int  ReqBits    = $bits(req_type);

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type pending_q[$];
   int      errors = 0;
   int      checked = 0;
   int      entries = 0;
   int      sent;
   int      send_idle_pct;
   int      stall_pct;
   longint  cycles = 0;

   segment_box_clip_test dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // n1/d1 < n2/d2 with positive denominators (exact, 64-bit products suffice)
   function automatic bit ratio_less(longint n1, longint d1, longint n2, longint d2);
      return (n1 * d2) < (n2 * d1);
   endfunction

   // predict the response for one request
   function automatic rsp_type clip_predict(req_type r);
      rsp_type res;
      longint  x0, y0, x1, y1, bx0, by0, bx1, by1, dx, dy;
      longint  p[4];
      longint  q[4];
      longint  en, ed, xn, xd, rem;
      bit      have_en, have_ex;
      side_type side;
      logic [FracBits:0] t;
      res = '{OUT_MISS, SIDE_LEFT, '0};
      x0 = r.seg_start_x; y0 = r.seg_start_y;
      x1 = r.seg_end_x;   y1 = r.seg_end_y;
      bx0 = r.box_left;   by0 = r.box_top;
      if (r.box_width == 0 || r.box_height == 0) return res;
      bx1 = bx0 + longint'(r.box_width) - 1;
      by1 = by0 + longint'(r.box_height) - 1;
      dx = x1 - x0;
      dy = y1 - y0;
      if (dx == 0 && dy == 0) begin
         if (!(x0 < bx0 || y0 < by0 || x0 > bx1 || y0 > by1)) res.outcome = OUT_INSIDE;
         return res;
      end
      if ((x0 > x1 ? x0 : x1) < bx0 || (x0 < x1 ? x0 : x1) > bx1 ||
          (y0 > y1 ? y0 : y1) < by0 || (y0 < y1 ? y0 : y1) > by1) return res;
      if ((x0 < x1 ? x0 : x1) >= bx0 && (y0 < y1 ? y0 : y1) >= by0 &&
          (x0 > x1 ? x0 : x1) <= bx1 && (y0 > y1 ? y0 : y1) <= by1) begin
         res.outcome = OUT_INSIDE;
         return res;
      end
      p[0] = -dx; p[1] = dx; p[2] = -dy; p[3] = dy;
      q[0] = x0 - bx0; q[1] = bx1 - x0; q[2] = y0 - by0; q[3] = by1 - y0;
      en = 0; ed = 1; xn = 0; xd = 1;
      have_en = 0; have_ex = 0;
      side = SIDE_LEFT;
      for (int i = 0; i < 4; i++) begin
         if (p[i] == 0) begin
            if (q[i] < 0) return res;
         end else if (p[i] < 0) begin
            if (!have_en || ratio_less(en, ed, -q[i], -p[i])) begin
               en = -q[i]; ed = -p[i]; side = side_type'(i); have_en = 1;
            end
         end else begin
            if (!have_ex || ratio_less(q[i], p[i], xn, xd)) begin
               xn = q[i]; xd = p[i]; have_ex = 1;
            end
         end
      end
      if (!have_en || !have_ex || ratio_less(xn, xd, en, ed) || en > ed || en < 0)
         return res;
      if (en == ed) begin
         t = {1'b1, {FracBits{1'b0}}};
      end else begin
         rem = en;
         t = '0;
         for (int i = 0; i < FracBits; i++) begin
            rem = rem << 1;
            t = t << 1;
            if (rem >= ed) begin
               rem -= ed;
               t[0] = 1'b1;
            end
         end
      end
      res.outcome = OUT_ENTER;
      res.entry_side = side;
      res.entry_time = t;
      return res;
   endfunction

   // send one request, idling first at the current rate
   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      pending_q.push_back(clip_predict(r));
      sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // drive the response stall at the current rate
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_data);
            errors++;
         end else begin
            want = pending_q.pop_front();
            checked++;
            if (want.outcome == OUT_ENTER) entries++;
            if (rsp_data.outcome !== want.outcome)
               $display("%0t: outcome expected %s actual %0d", $time,
                        want.outcome.name(), rsp_data.outcome);
            if (rsp_data.entry_side !== want.entry_side)
               $display("%0t: entry_side expected %0d actual %0d", $time,
                        want.entry_side, rsp_data.entry_side);
            if (rsp_data.entry_time !== want.entry_time)
               $display("%0t: entry_time expected %0h actual %0h", $time,
                        want.entry_time, rsp_data.entry_time);
            if (rsp_data !== want) errors++;
         end
      end
   end

   // give up on a hang
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic req_type make_req(int sx, int sy, int ex, int ey,
                                        int bl, int bt, int bw, int bh);
      req_type r;
      r.seg_start_x = CoordBits'(sx); r.seg_start_y = CoordBits'(sy);
      r.seg_end_x = CoordBits'(ex);   r.seg_end_y = CoordBits'(ey);
      r.box_left = CoordBits'(bl);    r.box_top = CoordBits'(bt);
      r.box_width = (CoordBits-1)'(bw);
      r.box_height = (CoordBits-1)'(bh);
      return r;
   endfunction

   // drop valid and wait for every outstanding response
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(negedge clock);
   endtask

   // corner cases: degenerate boxes, points, rejects, inside, each side, ties
   task automatic test_directed();
      send_request(make_req(0, 0, 5, 5, 0, 0, 0, 10));
      send_request(make_req(0, 0, 5, 5, 0, 0, 10, 0));
      send_request(make_req(3, 3, 3, 3, 0, 0, 10, 10));
      send_request(make_req(30, 3, 30, 3, 0, 0, 10, 10));
      send_request(make_req(-20, -20, -5, -5, 0, 0, 10, 10));
      send_request(make_req(1, 1, 8, 8, 0, 0, 10, 10));
      send_request(make_req(-10, 5, 20, 5, 0, 0, 10, 10));
      send_request(make_req(20, 5, -10, 5, 0, 0, 10, 10));
      send_request(make_req(5, -10, 5, 20, 0, 0, 10, 10));
      send_request(make_req(5, 20, 5, -10, 0, 0, 10, 10));
      send_request(make_req(-10, -10, 20, 20, 0, 0, 10, 10));
      send_request(make_req(-10, 20, 20, -10, 0, 0, 10, 10));
      send_request(make_req(-5, 8, 8, -5, 0, 0, 10, 10));
      send_request(make_req(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
      send_request(make_req(32767, 32767, -32768, -32768, 0, 0, 32767, 32767));
      send_request(make_req(-32768, 0, 32767, 0, 32767, 0, 1, 1));
      send_request(make_req(5, 5, 20, 20, 0, 0, 10, 10));
      send_request(make_req(-32768, 32767, 32767, -32768, -100, -100, 200, 200));
      send_request(make_req(0, 0, 1, 0, 1, 0, 1, 1));
      send_request(make_req(-1, -2, 3, 5, 0, 0, 1, 1));
   endtask

   function automatic int rand_coord(int spread);
      if ($urandom_range(9) == 0) return $signed(16'($urandom()));
      return $signed(32'($urandom_range(2 * spread))) - spread;
   endfunction

   // random requests, mostly near a box so entries are common
   task automatic test_random(int count, int idle_pct, int stall_rate);
      req_type r;
      int bl, bt;
      send_idle_pct = idle_pct;
      stall_pct = stall_rate;
      repeat (count) begin
         if ($urandom_range(3) == 0) begin
            r = req_type'(ReqBits'({$urandom(), $urandom(), $urandom(), $urandom()}));
         end else begin
            bl = rand_coord(200);
            bt = rand_coord(200);
            r = make_req(bl + rand_coord(300), bt + rand_coord(300),
                         bl + rand_coord(300), bt + rand_coord(300),
                         bl, bt, $urandom_range(300), $urandom_range(300));
            if ($urandom_range(15) == 0) r.box_width = 15'($urandom());
         end
         send_request(r);
      end
   endtask

   // hold the sender until everything in flight has returned, then send 20 more
   task automatic test_drain_pause();
      wait_drained();
      repeat (30) @(negedge clock);
      test_random(20, 0, 0);
   endtask

   initial begin
      sent = 0;
      send_idle_pct = 0; stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(RandItems / 5, 0, 0);
      test_random(RandItems / 5, 72, 0);
      test_drain_pause();
      test_random(RandItems / 5, 0, 72);
      test_random(RandItems / 5, 12, 12);
      test_random(RandItems / 5, 0, 0);
      wait_drained();
      repeat (20) @(negedge clock);
      $display("Sent %0d requests, checked %0d responses (%0d box entries)",
               sent, checked, entries);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
